// ===== src/y86_instruction_fetch_decode_defines.svh =====
// assertion macros for the y86 fetch/decode block
// no dependencies; included by files that carry assertions
`ifndef Y86_INSTRUCTION_FETCH_DECODE_DEFINES_SVH
`define Y86_INSTRUCTION_FETCH_DECODE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define Y86FD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("y86fd assertion failed");
// delayed implication, disabled while reset is asserted
`define Y86FD_ASSERT_IMP2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("y86fd assertion failed");
`else
`define Y86FD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define Y86FD_ASSERT_IMP2(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/y86fd_pkg.sv =====
// types and constants for the y86 fetch/decode block
// no dependencies; imported by every module of the block
package y86fd_pkg;

    localparam logic [3:0] ICODE_HALT   = 4'd0;
    localparam logic [3:0] ICODE_NOP    = 4'd1;
    localparam logic [3:0] ICODE_CMOV   = 4'd2;
    localparam logic [3:0] ICODE_IRMOVQ = 4'd3;
    localparam logic [3:0] ICODE_RMMOVQ = 4'd4;
    localparam logic [3:0] ICODE_MRMOVQ = 4'd5;
    localparam logic [3:0] ICODE_OPQ    = 4'd6;
    localparam logic [3:0] ICODE_JXX    = 4'd7;
    localparam logic [3:0] ICODE_CALL   = 4'd8;
    localparam logic [3:0] ICODE_RET    = 4'd9;
    localparam logic [3:0] ICODE_PUSHQ  = 4'd10;
    localparam logic [3:0] ICODE_POPQ   = 4'd11;
    localparam logic [3:0] ICODE_IOTRAP = 4'd12;
    localparam logic [3:0] ICODE_BAD    = 4'd15;

    localparam logic [3:0] NO_REG       = 4'd15;
    localparam logic [3:0] FUN_NONE     = 4'd0;
    localparam logic [3:0] FUN_MAX_CMOV = 4'd6;
    localparam logic [3:0] FUN_MAX_JXX  = 4'd6;
    localparam logic [3:0] FUN_MAX_OPQ  = 4'd3;
    localparam logic [3:0] FUN_MAX_TRAP = 4'd5;

    localparam logic [3:0] LEN_SHORT    = 4'd1;
    localparam logic [3:0] LEN_REG      = 4'd2;
    localparam logic [3:0] LEN_DEST     = 4'd9;
    localparam logic [3:0] LEN_MOVE     = 4'd10;

    typedef struct packed {
        logic [63:0] pc;
        logic [7:0]  opcode_byte;
        logic [7:0]  register_byte;
        logic [63:0] tail_bytes;
    } t_fd_in;

    typedef struct packed {
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [63:0] const_value;
        logic [63:0] next_pc;
        logic        bad_instruction;
    } t_fd_out;

endpackage

// ===== src/y86fd_decode.sv =====
// combinational decode of one y86-64 instruction word
// depends on y86fd_pkg
module y86fd_decode import y86fd_pkg::*; (
    input  t_fd_in  i_insn,
    output t_fd_out o_dec
);

    logic [3:0]  ic;
    logic [3:0]  fn;
    logic [3:0]  ra_n;
    logic [3:0]  rb_n;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [3:0]  len;
    logic [63:0] cval;
    logic        bad;

    assign ic   = i_insn.opcode_byte[7:4];
    assign fn   = i_insn.opcode_byte[3:0];
    assign ra_n = i_insn.register_byte[7:4];
    assign rb_n = i_insn.register_byte[3:0];

    always_comb begin
        ra   = NO_REG;
        rb   = NO_REG;
        cval = 64'd0;
        len  = LEN_SHORT;
        bad  = 1'b0;
        unique case (ic) inside
            ICODE_HALT, ICODE_NOP, ICODE_RET: begin
                bad = (fn != FUN_NONE);
            end
            ICODE_CMOV: begin
                ra  = ra_n;
                rb  = rb_n;
                len = LEN_REG;
                bad = (fn > FUN_MAX_CMOV);
            end
            ICODE_OPQ: begin
                ra  = ra_n;
                rb  = rb_n;
                len = LEN_REG;
                bad = (fn > FUN_MAX_OPQ);
            end
            ICODE_PUSHQ, ICODE_POPQ: begin
                ra  = ra_n;
                rb  = rb_n;
                len = LEN_REG;
                bad = (fn != FUN_NONE) || (rb_n != NO_REG);
            end
            ICODE_IRMOVQ: begin
                ra   = ra_n;
                rb   = rb_n;
                len  = LEN_MOVE;
                cval = i_insn.tail_bytes;
                bad  = (fn != FUN_NONE) || (ra_n != NO_REG);
            end
            ICODE_RMMOVQ, ICODE_MRMOVQ: begin
                ra   = ra_n;
                rb   = rb_n;
                len  = LEN_MOVE;
                cval = i_insn.tail_bytes;
                bad  = (fn != FUN_NONE);
            end
            ICODE_JXX: begin
                len  = LEN_DEST;
                cval = {i_insn.tail_bytes[55:0], i_insn.register_byte};
                bad  = (fn > FUN_MAX_JXX);
            end
            ICODE_CALL: begin
                len  = LEN_DEST;
                cval = {i_insn.tail_bytes[55:0], i_insn.register_byte};
                bad  = (fn != FUN_NONE);
            end
            ICODE_IOTRAP: begin
                bad = (fn > FUN_MAX_TRAP);
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    assign o_dec.icode           = bad ? ICODE_BAD : ic;
    assign o_dec.ifun            = fn;
    assign o_dec.reg_a           = ra;
    assign o_dec.reg_b           = rb;
    assign o_dec.const_value     = cval;
    assign o_dec.next_pc         = i_insn.pc + {60'd0, len};
    assign o_dec.bad_instruction = bad;

endmodule

// ===== src/y86_instruction_fetch_decode.sv =====
// top level of the y86-64 fetch/decode block: input register, decode, result register
// depends on y86fd_pkg, y86fd_decode and y86_instruction_fetch_decode_defines.svh
//
//  channel   handshake             payload
//  input     start / busy          i_insn   (t_fd_in)
//  result    o_strobe (no stall)   o_result (t_fd_out)
//
// an accepted word is marked in r_in_vld, then r_strobe raises its result strobe
// a new word can be taken every cycle while busy is low; busy is high only around reset
// reset is synchronous, active low, and clears the valid pipeline
// the receiver cannot stall, so nothing ever backs up
`include "y86_instruction_fetch_decode_defines.svh"

module y86_instruction_fetch_decode import y86fd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_fd_in  i_insn,
    output logic    o_strobe,
    output t_fd_out o_result
);

    logic    r_busy;
    logic    r_in_vld;
    t_fd_in  r_insn;
    logic    r_strobe;
    t_fd_out r_result;
    t_fd_out n_result;
    logic    accept;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= accept;
            r_strobe <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_insn <= i_insn;
        end
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    y86fd_decode u_decode (
        .i_insn (r_insn),
        .o_dec  (n_result)
    );

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `Y86FD_ASSERT_IMP2(a_accept_strobe, i_clk, i_rst_n, accept, o_strobe)
    `Y86FD_ASSERT_IMP(a_strobe_src, i_clk, i_rst_n, o_strobe, $past(r_in_vld))
    `Y86FD_ASSERT_IMP(a_bad_code, i_clk, i_rst_n, o_strobe, (o_result.bad_instruction == (o_result.icode == ICODE_BAD)))
    `Y86FD_ASSERT_IMP2(a_ifun_kept, i_clk, i_rst_n, accept, (o_result.ifun == $past(i_insn.opcode_byte[3:0], 2)))

endmodule
